// ===== rtl/signed_binary_to_decimal_ascii_assert.svh =====
// Assertion macros for the decimal text converter controller.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SB2D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SB2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sb2d_pkg.sv =====
// Shared constants and controller/datapath interface types for the decimal text converter.
package sb2d_pkg;

    // Width of the signed input value.
    localparam int VALUE_WIDTH = 32;

    // Decimal digits needed for the largest magnitude, 2 to the power VALUE_WIDTH-1.
    localparam int NUM_DIGITS = ((((VALUE_WIDTH - 1) * 1233) >> 12) + 1);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    // ASCII codes.
    localparam int CHAR_W = 8;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic dabble;
        logic skip_digit;
        logic emit_sign;
        logic emit_digit;
    } sb2d_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bits_done;
        logic top_zero;
        logic final_digit;
        logic negative;
    } sb2d_sts_t;

endpackage

// ===== rtl/signed_binary_to_decimal_ascii.sv =====
// Top level: signed binary to decimal ASCII converter, one character strobed per cycle.
// Each value passes through the accepting cycle, the double-dabble shifts (one per input bit),
// the skipped leading-zero digits, a skip-exit cycle that also strobes any minus sign, and
// the emitted digits; a new value is taken only once busy has dropped.
// The receiver cannot stall; busy drops in the cycle that strobes the last character.
// Reset (rst_n, asynchronous, active low) returns the controller to idle with no strobe.
module signed_binary_to_decimal_ascii
    import sb2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  value,
    output logic                    busy,
    output logic                    strobe,
    output logic [CHAR_W-1:0]       character,
    output logic                    last
);

    sb2d_cmd_t cmd;
    sb2d_sts_t sts;

    // Sequencer.
    sb2d_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Conversion datapath.
    sb2d_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule

// ===== rtl/sb2d_datapath.sv =====
// Datapath: magnitude and BCD registers, double-dabble shifter, counters and output registers.
module sb2d_datapath
    import sb2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  sb2d_cmd_t               cmd,
    output sb2d_sts_t               sts,
    output logic                    strobe,
    output logic [CHAR_W-1:0]       character,
    output logic                    last
);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic                   neg_reg;
    logic                   strobe_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic [BCD_W-1:0]       bcd_adj;
    logic [VALUE_WIDTH-1:0] value_mag;
    logic [3:0]             top_digit;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Unsigned magnitude; the most negative value maps to 2 to the power VALUE_WIDTH-1.
    assign value_mag = value[VALUE_WIDTH-1] ? ((~value) + VALUE_WIDTH'(1)) : value;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // Conversion registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg     <= value_mag;
            neg_reg     <= value[VALUE_WIDTH-1];
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= DIG_CNT_W'(NUM_DIGITS - 1);
        end
        else if (cmd.dabble)
        begin
            bcd_reg     <= {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_reg     <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
        end
        else if (cmd.skip_digit || cmd.emit_digit)
        begin
            bcd_reg     <= {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_reg <= dig_cnt_reg - DIG_CNT_W'(1);
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_sign | cmd.emit_digit;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CHAR_ZERO + {4'd0, top_digit};
            last_reg <= (dig_cnt_reg == '0);
        end
    end

    assign sts.bits_done   = (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1));
    assign sts.top_zero    = (top_digit == 4'd0);
    assign sts.final_digit = (dig_cnt_reg == '0);
    assign sts.negative    = neg_reg;

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/sb2d_ctrl.sv =====
// Controller: sequences load, double-dabble shifts, leading-zero skip and character emission.
module sb2d_ctrl
    import sb2d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  sb2d_sts_t sts,
    output sb2d_cmd_t cmd,
    output logic      busy
);

`include "signed_binary_to_decimal_ascii_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SKIP    = 4'b0100,
        ST_EMIT    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.dabble = 1'b1;
                if (sts.bits_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zeros, but always keep the units digit.
                if (sts.top_zero && !sts.final_digit)
                begin
                    cmd.skip_digit = 1'b1;
                end
                else
                begin
                    cmd.emit_sign = sts.negative;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_digit = 1'b1;
                if (sts.final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Checks on the sequencing.
    `SB2D_ASSERT_NEXT(a_start_converts, (state_reg == ST_IDLE) && start,
        state_reg == ST_CONVERT, "Accepted transfer did not start a conversion.")
    `SB2D_ASSERT_NEXT(a_convert_holds, (state_reg == ST_CONVERT) && !sts.bits_done,
        state_reg == ST_CONVERT, "Conversion left before all bits were shifted.")
    `SB2D_ASSERT_NEXT(a_final_returns, (state_reg == ST_EMIT) && sts.final_digit,
        state_reg == ST_IDLE, "Controller did not return to idle after the final digit.")
    `SB2D_ASSERT_NOW(a_emit_exclusive, cmd.emit_sign,
        (state_reg == ST_SKIP) && !cmd.skip_digit, "Sign emitted outside the skip exit.")

endmodule

// ===== tb/decimal_text_checker.sv =====
// Checker that predicts and compares the decimal text burst for each converted value.
`timescale 1ns / 100ps

module decimal_text_checker
    import sb2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  logic                    busy,
    input  logic                    strobe,
    input  logic [CHAR_W-1:0]       character,
    input  logic                    last,
    output int unsigned             errors,
    output int unsigned             pending
);

    localparam int RADIX = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              final_char;
    } text_char_t;

    // Characters still owed by the block, oldest first.
    text_char_t expected_text[$];

    // Appends the decimal text of one signed value to the expected characters.
    function automatic void format_decimal(input logic [VALUE_WIDTH-1:0] word);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [CHAR_W-1:0]      digits[$];
        text_char_t             entry;
        logic                   negative;
        negative = word[VALUE_WIDTH-1];
        // The most negative value negates to its own bit pattern, read as unsigned.
        magnitude = negative ? (~word + 1'b1) : word;
        do begin
            digits.push_front(CHAR_ZERO + CHAR_W'(magnitude % RADIX));
            magnitude = magnitude / RADIX;
        end while (magnitude != 0);
        if (negative) begin
            entry.code       = CHAR_MINUS;
            entry.final_char = 1'b0;
            expected_text.push_back(entry);
        end
        foreach (digits[i]) begin
            entry.code       = digits[i];
            entry.final_char = (i == digits.size() - 1);
            expected_text.push_back(entry);
        end
    endfunction

    // Counts a failure; only the first few are described.
    function automatic void flag_error(input string what, input int unsigned want,
                                       input int unsigned got);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // Record each accepted value and compare each strobed character.
    always @(posedge clk) begin
        text_char_t want;
        if (rst_n) begin
            if (start && !busy) begin
                format_decimal(value);
            end
            if (strobe) begin
                if (expected_text.size() == 0) begin
                    flag_error("character with no value pending", 0, 32'(character));
                end
                else begin
                    want = expected_text.pop_front();
                    if (character !== want.code) begin
                        flag_error("character code", 32'(want.code), 32'(character));
                    end
                    if (last !== want.final_char) begin
                        flag_error("last flag", 32'(want.final_char), 32'(last));
                    end
                end
            end
        end
        pending <= expected_text.size();
    end

endmodule

// ===== tb/signed_binary_to_decimal_ascii_tb.sv =====
// Testbench top: drives values into the decimal text converter and gives the verdict.
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;
    import sb2d_pkg::*;

    localparam int          RANDOM_PER_PHASE = 100;
    localparam int          MAX_GAP          = 60;
    localparam int          DRAIN_CYCLES     = 50;
    localparam int unsigned CYCLE_LIMIT      = 200000;

    logic                   clk   = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [VALUE_WIDTH-1:0] value = '0;
    logic                   busy;
    logic                   strobe;
    logic [CHAR_W-1:0]      character;
    logic                   last;
    int unsigned            errors;
    int unsigned            pending;
    int unsigned            cycle_count;
    int                     idle_pct;

    // Values at the edges of the range and at digit-count boundaries.
    logic [VALUE_WIDTH-1:0] directed_values[$] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd9, 32'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
        32'd1000000000, -32'sd1000000000, 32'd999999999, 32'd1234567890,
        -32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFF6
    };

    signed_binary_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    decimal_text_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block never finishes.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Random value: full range, a random digit count, near the extremes, or a power of ten.
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        longint unsigned scale;
        longint unsigned magnitude;
        int              digit_count;
        logic            negative;
        negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: begin
                digit_count = $urandom_range(1, 10);
                scale = 1;
                repeat (digit_count) scale = scale * 10;
                magnitude = {$urandom, $urandom} % scale;
                if (magnitude > 64'h7FFF_FFFF) begin
                    magnitude = 64'h7FFF_FFFF;
                end
            end
            2: begin
                magnitude = 64'h7FFF_FFFF - $urandom_range(0, 20);
                if (negative) begin
                    magnitude = magnitude + 1;
                end
            end
            default: begin
                scale = 1;
                repeat ($urandom_range(0, 9)) scale = scale * 10;
                magnitude = scale + $urandom_range(0, 2) - 1;
            end
        endcase
        return negative ? VALUE_WIDTH'(-magnitude) : VALUE_WIDTH'(magnitude);
    endfunction

    // One transfer into the block, with an optional idle stretch ahead of it.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] word);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        start <= 1'b1;
        value <= word;
        do @(posedge clk); while (busy);
    endtask

    initial begin
        idle_pct = 11;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values, then random ones under three idling patterns.
        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        repeat (RANDOM_PER_PHASE) send_value(random_value());
        idle_pct = 74;
        repeat (RANDOM_PER_PHASE) send_value(random_value());
        idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_value(random_value());
        start <= 1'b0;

        // Let the last bursts drain, then watch for stray characters.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
